// File: rtl/core/dstar_slow_data_aprs_extractor_unit_macros.svh
// Assertion macros for the slow-data extractor.
// Included by modules that carry concurrent assertions.
`ifndef DSTAR_SLOW_DATA_APRS_EXTRACTOR_UNIT_MACROS_SVH
`define DSTAR_SLOW_DATA_APRS_EXTRACTOR_UNIT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define DSAX_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Implication that also holds while reset is asserted.
`define DSAX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/dsax_pkg.sv
// Package for the slow-data extractor: constants, types and helper functions.
// No dependencies.
`timescale 1ns / 1ps
package dsax_pkg;
  localparam int Channels = 3;
  localparam int ChW = 2;
  localparam int MaxSentence = 300;
  localparam int MaxDelivered = 200;
  localparam int LenW = 9;

  localparam logic [3:0] PhIdle = 4'd0;
  localparam logic [3:0] PhD1 = 4'd1;
  localparam logic [3:0] PhD2 = 4'd2;
  localparam logic [3:0] PhC1 = 4'd3;
  localparam logic [3:0] PhR = 4'd4;
  localparam logic [3:0] PhC2 = 4'd5;
  localparam logic [3:0] PhK1 = 4'd6;
  localparam logic [3:0] PhK2 = 4'd7;
  localparam logic [3:0] PhK3 = 4'd8;
  localparam logic [3:0] PhK4 = 4'd9;
  localparam logic [3:0] PhBody = 4'd10;

  localparam logic [1:0] CodeNone = 2'd0;
  localparam logic [1:0] CodeMismatch = 2'd1;
  localparam logic [1:0] CodeBadCrc = 2'd2;
  localparam logic [1:0] CodeOverflow = 2'd3;

  typedef struct packed {
    logic        second_half;
    logic [23:0] held;
    logic [3:0]  phase;
    logic [LenW-1:0] len;
    logic [31:0] cks;
    logic [15:0] crc;
    logic        taken;
  } ctx_t;

  typedef struct packed {
    logic [2:0]  count;
    logic [4:0][7:0] chars;
    logic        ok;
    logic [1:0]  code;
  } res_t;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] r;
    logic x;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      x = r[0] ^ b[i];
      r = {1'b0, r[15:1]};
      if (x) r = r ^ 16'h8408;
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
  endfunction

  function automatic logic [31:0] hex_word(logic [15:0] v);
    return {hex_char(v[15:12]), hex_char(v[11:8]), hex_char(v[7:4]), hex_char(v[3:0])};
  endfunction
endpackage

// File: rtl/core/dsax_if.sv
// Valid/ready stream interfaces for the extractor's input frames and output results.
// Depends on nothing; the payload fields are fixed in each interface.
`timescale 1ns / 1ps
interface dsax_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [1:0] channel;
  logic [7:0] seq;
  logic [7:0] slow_byte0;
  logic [7:0] slow_byte1;
  logic [7:0] slow_byte2;
  modport source (output valid, func, channel, seq, slow_byte0, slow_byte1, slow_byte2,
                  input ready);
  modport sink (input valid, func, channel, seq, slow_byte0, slow_byte1, slow_byte2,
                output ready);
endinterface

interface dsax_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] body_count;
  logic [7:0] body_char0;
  logic [7:0] body_char1;
  logic [7:0] body_char2;
  logic [7:0] body_char3;
  logic [7:0] body_char4;
  logic       sentence_ok;
  logic [1:0] discard_code;
  modport source (output valid, body_count, body_char0, body_char1, body_char2, body_char3,
                  body_char4, sentence_ok, discard_code, input ready);
  modport sink (input valid, body_count, body_char0, body_char1, body_char2, body_char3,
                body_char4, sentence_ok, discard_code, output ready);
endinterface

// File: rtl/core/dstar_slow_data_aprs_extractor_unit.sv
// Slow-data GPS sentence extractor, top level; one context per channel in a RAM.
// Depends on dsax_pkg, dsax_if and dsax_parse.
`timescale 1ns / 1ps
// The context RAM is read into rd_q at the edge that accepts a frame, with the frame
// in the s1 registers; the parse then runs, and the write-back and result register
// res_q update at the next advancing edge. Throughput is one item per cycle unless the output stalls.
// The context RAM has one read and one write port; a frame for the channel that
// the previous frame just updated takes the fresh context from a forwarding
// register. Reset clears a per-channel valid bit, so no clearing pass runs.
// Channels 3 and above give all-zero results and touch no state.
`include "dstar_slow_data_aprs_extractor_unit_macros.svh"
module dstar_slow_data_aprs_extractor_unit (
  input logic clk_i,
  input logic rst_ni,
  dsax_in_if.sink in_i,
  dsax_out_if.source out_o
);
  dsax_pkg::ctx_t mem_q [dsax_pkg::Channels];
  dsax_pkg::ctx_t rd_q, fwd_q, ctx_cur, ctx_nxt, ctx_rst;
  logic [dsax_pkg::Channels-1:0] vld_q;
  logic s1_v_q, fwd_v_q, out_v_q;
  logic [1:0] s1_ch_q, fwd_ch_q;
  logic s1_func_q;
  logic [7:0] s1_seq_q, s1_b0_q, s1_b1_q, s1_b2_q;
  dsax_pkg::res_t res, res_q;
  logic adv, s1_ok;

  assign adv = !out_v_q || out_o.ready;
  assign in_i.ready = adv;
  assign s1_ok = s1_ch_q < 2'(dsax_pkg::Channels);

  always_ff @(posedge clk_i) begin
    if (in_i.valid && adv && in_i.channel < 2'(dsax_pkg::Channels))
      rd_q <= mem_q[in_i.channel];
    if (adv && s1_v_q && s1_ok) mem_q[s1_ch_q] <= ctx_nxt;
  end

  always_comb begin
    ctx_rst = rd_q;
    ctx_rst.second_half = 1'b0;
    ctx_rst.phase = dsax_pkg::PhIdle;
    ctx_rst.len = '0;
    ctx_rst.crc = 16'hffff;
    ctx_rst.taken = 1'b0;
    if (fwd_v_q && fwd_ch_q == s1_ch_q) ctx_cur = fwd_q;
    else if (vld_q[s1_ch_q]) ctx_cur = rd_q;
    else ctx_cur = ctx_rst;
  end

  dsax_parse u_parse (
    .ctx_i(ctx_cur), .func_i(s1_func_q), .seq_i(s1_seq_q),
    .b0_i(s1_b0_q), .b1_i(s1_b1_q), .b2_i(s1_b2_q),
    .ctx_o(ctx_nxt), .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      fwd_v_q <= 1'b0;
      out_v_q <= 1'b0;
      vld_q <= '0;
    end else if (adv) begin
      s1_v_q <= in_i.valid;
      out_v_q <= s1_v_q;
      fwd_v_q <= s1_v_q && s1_ok;
      if (s1_v_q && s1_ok) vld_q[s1_ch_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ch_q <= in_i.channel;
      s1_func_q <= in_i.func;
      s1_seq_q <= in_i.seq;
      s1_b0_q <= in_i.slow_byte0;
      s1_b1_q <= in_i.slow_byte1;
      s1_b2_q <= in_i.slow_byte2;
      fwd_q <= ctx_nxt;
      fwd_ch_q <= s1_ch_q;
      res_q <= s1_ok ? res : '0;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.body_count = res_q.count;
  assign out_o.body_char0 = res_q.chars[0];
  assign out_o.body_char1 = res_q.chars[1];
  assign out_o.body_char2 = res_q.chars[2];
  assign out_o.body_char3 = res_q.chars[3];
  assign out_o.body_char4 = res_q.chars[4];
  assign out_o.sentence_ok = res_q.ok;
  assign out_o.discard_code = res_q.code;

  `DSAX_ASSERT(a_ok_nocode, clk_i, rst_ni, out_v_q && res_q.ok |-> res_q.code == dsax_pkg::CodeNone, "commit with discard code")
  `DSAX_ASSERT(a_cnt, clk_i, rst_ni, out_v_q |-> res_q.count <= 3'd5, "body count above five")
  `DSAX_ASSERT(a_hold, clk_i, rst_ni, out_v_q && !out_o.ready |=> out_v_q && $stable(res_q), "result changed while stalled")
  `DSAX_ASSERT_ALWAYS(a_rst, clk_i, !rst_ni |-> !out_v_q, "output valid in reset")
endmodule

// File: rtl/core/dsax_parse.sv
// Combinational step of the parser for one frame against one channel context.
// Depends on dsax_pkg.
`timescale 1ns / 1ps
module dsax_parse (
  input  dsax_pkg::ctx_t ctx_i,
  input  logic       func_i,
  input  logic [7:0] seq_i,
  input  logic [7:0] b0_i,
  input  logic [7:0] b1_i,
  input  logic [7:0] b2_i,
  output dsax_pkg::ctx_t ctx_o,
  output dsax_pkg::res_t res_o
);
  always_comb begin
    dsax_pkg::ctx_t c;
    dsax_pkg::res_t r;
    logic [4:0][7:0] feed;
    logic [7:0] d0, d1, d2, ch;
    logic done;
    logic [dsax_pkg::LenW-1:0] pos;
    c = ctx_i;
    r = '0;
    done = 1'b0;
    d0 = b0_i ^ 8'h70;
    d1 = b1_i ^ 8'h4f;
    d2 = b2_i ^ 8'h93;
    feed = {d2, d1, d0, ctx_i.held[7:0], ctx_i.held[15:8]};
    pos = '0;
    if (func_i) begin
      c = '0;
      c.crc = 16'hffff;
      c.held = ctx_i.held;
      c.cks = ctx_i.cks;
    end else if (seq_i[6]) begin
    end else if (seq_i[4:0] == 5'd0) begin
      c.second_half = 1'b0;
    end else if (ctx_i.taken) begin
    end else if (!ctx_i.second_half) begin
      c.held = {d0, d1, d2};
      c.second_half = 1'b1;
    end else begin
      c.second_half = 1'b0;
      if (ctx_i.held[23:20] == 4'h3) begin
        for (int i = 0; i < 5; i++) begin
          ch = feed[i];
          if (!done) begin
            if (c.phase == dsax_pkg::PhIdle && ch == 8'h24) begin
              c.phase = dsax_pkg::PhD1;
              c.len = 9'd1;
            end else if ((c.phase == dsax_pkg::PhD1 && ch == 8'h24) ||
                         (c.phase == dsax_pkg::PhD2 && ch == 8'h43) ||
                         (c.phase == dsax_pkg::PhC1 && ch == 8'h52) ||
                         (c.phase == dsax_pkg::PhR && ch == 8'h43)) begin
              c.phase = c.phase + 4'd1;
              c.len = c.len + 9'd1;
            end else if (c.phase >= dsax_pkg::PhC2 && c.phase <= dsax_pkg::PhK3) begin
              unique case (c.phase)
                dsax_pkg::PhC2: c.cks[31:24] = ch;
                dsax_pkg::PhK1: c.cks[23:16] = ch;
                dsax_pkg::PhK2: c.cks[15:8] = ch;
                default: c.cks[7:0] = ch;
              endcase
              c.phase = c.phase + 4'd1;
              c.len = c.len + 9'd1;
            end else if (c.phase == dsax_pkg::PhK4 && ch == 8'h2c) begin
              c.phase = dsax_pkg::PhBody;
              c.len = c.len + 9'd1;
              c.crc = 16'hffff;
            end else if (c.phase == dsax_pkg::PhBody) begin
              pos = c.len - 9'd10;
              if (pos < 9'(dsax_pkg::MaxDelivered)) begin
                r.chars[r.count] = ch;
                r.count = r.count + 3'd1;
              end
              c.len = c.len + 9'd1;
              c.crc = dsax_pkg::crc_byte(c.crc, ch);
              if (ch != 8'h0d) begin
                if (c.len >= 9'(dsax_pkg::MaxSentence)) begin
                  c.phase = dsax_pkg::PhIdle;
                  c.len = '0;
                  r.code = dsax_pkg::CodeOverflow;
                end
              end else if (dsax_pkg::hex_word(~c.crc) == c.cks) begin
                c.phase = dsax_pkg::PhIdle;
                c.len = '0;
                c.taken = 1'b1;
                r.ok = 1'b1;
                done = 1'b1;
              end else begin
                c.phase = dsax_pkg::PhIdle;
                c.len = '0;
                r.code = dsax_pkg::CodeBadCrc;
              end
            end else begin
              if (c.phase != dsax_pkg::PhIdle) r.code = dsax_pkg::CodeMismatch;
              c.phase = dsax_pkg::PhIdle;
              c.len = '0;
            end
          end
        end
      end
    end
    ctx_o = c;
    res_o = r;
  end
endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the slow-data GPS sentence extractor.
// Depends on dsax_pkg, dsax_if and the extractor top level.
`timescale 1ns / 1ps
module tb_top;
  typedef struct {
    logic [2:0]      count;
    logic [4:0][7:0] chars;
    logic            ok;
    logic [1:0]      code;
  } sentence_res_t;

  logic clk_i;
  logic rst_ni;
  int   fail_cnt;
  bit   hold_off;
  bit   hold_off_req;

  dsax_in_if  in_if ();
  dsax_out_if out_if ();

  dstar_slow_data_aprs_extractor_unit DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Per-channel decoder state mirrored by the predictor.
  logic            half_seen [dsax_pkg::Channels];
  logic [23:0]     first_half [dsax_pkg::Channels];
  logic [3:0]      phase [dsax_pkg::Channels];
  int              sent_len [dsax_pkg::Channels];
  logic [31:0]     crc_text [dsax_pkg::Channels];
  logic [15:0]     crc_acc [dsax_pkg::Channels];
  logic            taken [dsax_pkg::Channels];
  sentence_res_t   pending_q[$];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) r = (r >> 1) ^ 16'h8408;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic logic [7:0] nib_ascii(logic [3:0] n);
    if (n < 10) return 8'h30 + n;
    return 8'h41 + n - 10;
  endfunction

  function automatic logic [31:0] crc_ascii(logic [15:0] v);
    return {nib_ascii(v[15:12]), nib_ascii(v[11:8]), nib_ascii(v[7:4]), nib_ascii(v[3:0])};
  endfunction

  function automatic void clear_ctx(int ch);
    half_seen[ch] = 0; first_half[ch] = '0; phase[ch] = dsax_pkg::PhIdle; sent_len[ch] = 0;
    crc_text[ch] = '0; crc_acc[ch] = 16'hffff; taken[ch] = 0;
  endfunction

  function automatic sentence_res_t predict_frame(logic fn, logic [1:0] ch, logic [7:0] sq,
                                                  logic [7:0] s0, logic [7:0] s1,
                                                  logic [7:0] s2);
    sentence_res_t r;
    logic [7:0] b0, b1, b2, c;
    logic [7:0] feed [5];
    int pos;
    r.count = 0; r.chars = '0; r.ok = 0; r.code = dsax_pkg::CodeNone;
    if (ch >= dsax_pkg::Channels) return r;
    if (fn) begin
      clear_ctx(ch);
      return r;
    end
    if (sq[6]) return r;
    if (sq[4:0] == 0) begin
      half_seen[ch] = 0;
      return r;
    end
    if (taken[ch]) return r;
    b0 = s0 ^ 8'h70; b1 = s1 ^ 8'h4f; b2 = s2 ^ 8'h93;
    if (!half_seen[ch]) begin
      first_half[ch] = {b0, b1, b2};
      half_seen[ch] = 1;
      return r;
    end
    half_seen[ch] = 0;
    if (first_half[ch][23:20] != 4'h3) return r;
    feed[0] = first_half[ch][15:8]; feed[1] = first_half[ch][7:0];
    feed[2] = b0; feed[3] = b1; feed[4] = b2;
    for (int i = 0; i < 5; i++) begin
      c = feed[i];
      if (phase[ch] == dsax_pkg::PhIdle && c == "$") begin
        phase[ch] = dsax_pkg::PhD1; sent_len[ch] = 1;
      end else if ((phase[ch] == dsax_pkg::PhD1 && c == "$") ||
                   (phase[ch] == dsax_pkg::PhD2 && c == "C") ||
                   (phase[ch] == dsax_pkg::PhC1 && c == "R") ||
                   (phase[ch] == dsax_pkg::PhR && c == "C")) begin
        phase[ch] = phase[ch] + 1; sent_len[ch]++;
      end else if (phase[ch] >= dsax_pkg::PhC2 && phase[ch] <= dsax_pkg::PhK3) begin
        crc_text[ch][(3 - (phase[ch] - dsax_pkg::PhC2)) * 8 +: 8] = c;
        phase[ch] = phase[ch] + 1; sent_len[ch]++;
      end else if (phase[ch] == dsax_pkg::PhK4 && c == ",") begin
        phase[ch] = dsax_pkg::PhBody; sent_len[ch]++; crc_acc[ch] = 16'hffff;
      end else if (phase[ch] == dsax_pkg::PhBody) begin
        pos = sent_len[ch] - 10;
        if (pos < dsax_pkg::MaxDelivered && r.count < 5) begin
          r.chars[r.count] = c;
          r.count++;
        end
        sent_len[ch]++;
        crc_acc[ch] = crc_step(crc_acc[ch], c);
        if (c != 8'h0d) begin
          if (sent_len[ch] >= dsax_pkg::MaxSentence) begin
            phase[ch] = dsax_pkg::PhIdle; sent_len[ch] = 0; r.code = dsax_pkg::CodeOverflow;
          end
        end else begin
          phase[ch] = dsax_pkg::PhIdle; sent_len[ch] = 0;
          if (crc_ascii(~crc_acc[ch]) == crc_text[ch]) begin
            taken[ch] = 1; r.ok = 1;
            break;
          end
          r.code = dsax_pkg::CodeBadCrc;
        end
      end else begin
        if (phase[ch] != dsax_pkg::PhIdle) r.code = dsax_pkg::CodeMismatch;
        phase[ch] = dsax_pkg::PhIdle; sent_len[ch] = 0;
      end
    end
    return r;
  endfunction

  task automatic send_frame(logic fn, logic [1:0] ch, logic [7:0] sq,
                            logic [7:0] s0, logic [7:0] s1, logic [7:0] s2);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1; in_if.func <= fn; in_if.channel <= ch; in_if.seq <= sq;
    in_if.slow_byte0 <= s0; in_if.slow_byte1 <= s1; in_if.slow_byte2 <= s2;
    do @(posedge clk_i); while (!in_if.ready);
    pending_q.push_back(predict_frame(fn, ch, sq, s0, s1, s2));
    @(negedge clk_i);
  endtask

  // Sends two frames forming one six-byte block of plain bytes.
  task automatic send_block(logic [1:0] ch, logic [7:0] hdr, logic [7:0] d [5]);
    send_frame(0, ch, 8'($urandom_range(1, 31)), hdr ^ 8'h70, d[0] ^ 8'h4f, d[1] ^ 8'h93);
    send_frame(0, ch, 8'($urandom_range(1, 31)), d[2] ^ 8'h70, d[3] ^ 8'h4f, d[4] ^ 8'h93);
  endtask

  // Streams a whole sentence on one channel; corrupt spoils the checksum text.
  task automatic send_sentence(logic [1:0] ch, int body_len, bit corrupt);
    logic [7:0] txt[$];
    logic [7:0] body[$];
    logic [7:0] blk [5];
    logic [15:0] c;
    logic [31:0] hx;
    c = 16'hffff;
    for (int i = 0; i < body_len; i++) begin
      body.push_back(8'($urandom_range(32, 126)));
      c = crc_step(c, body[i]);
    end
    body.push_back(8'h0d);
    c = crc_step(c, 8'h0d);
    hx = crc_ascii(~c);
    if (corrupt) hx[7:0] = hx[7:0] ^ 8'h01;
    txt = '{"$", "$", "C", "R", "C", hx[31:24], hx[23:16], hx[15:8], hx[7:0], ","};
    txt = {txt, body};
    send_frame(1, ch, 0, 0, 0, 0);
    while (txt.size() > 0) begin
      for (int k = 0; k < 5; k++) blk[k] = (txt.size() > 0) ? txt.pop_front() : 8'h20;
      send_block(ch, 8'h30 | 8'($urandom_range(0, 15)), blk);
    end
  endtask

  task automatic test_edges();
    logic [7:0] blk [5];
    send_frame(0, 0, 8'hff, 8'hff, 8'hff, 8'hff);
    send_frame(0, 3, 8'h01, 8'h00, 8'h00, 8'h00);
    send_frame(1, 3, 8'h00, 8'hff, 8'hff, 8'hff);
    send_frame(0, 1, 8'h20, 8'h00, 8'h00, 8'h00);
    blk = '{"$", "$", "C", "R", "X"};
    send_block(1, 8'h30, blk);
    blk = '{"$", "$", "$", "Q", "Q"};
    send_block(1, 8'h3f, blk);
    blk = '{"$", "$", "C", "R", "C"};
    send_block(2, 8'h5a, blk);
    send_frame(0, 2, 8'h01, 8'h40, 8'h4f, 8'h93);
    send_frame(0, 2, 8'h80, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_good_sentences();
    send_sentence(0, 3, 0);
    send_sentence(1, 0, 0);
    send_frame(0, 0, 8'h05, 8'h40, 8'h7a, 8'hb7);
  endtask

  task automatic test_bad_crc();
    send_sentence(2, 7, 1);
  endtask

  task automatic test_long_sentences();
    send_sentence(0, 195, 0);
    send_sentence(1, 295, 0);
  endtask

  task automatic test_backpressure();
    hold_off_req = 1;
    repeat (20) send_frame(0, 0, 8'($urandom_range(1, 31)), 8'($urandom), 8'($urandom),
                           8'($urandom));
    hold_off_req = 0;
  endtask

  task automatic test_random();
    int pick;
    for (int n = 0; n < 40; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) send_sentence(2'($urandom_range(0, 2)), $urandom_range(0, 12),
                                  $urandom_range(0, 3) == 0);
      else send_frame(1'($urandom_range(0, 7) == 0), 2'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // Receiver: lowers ready at random before taking each transaction, and holds off
  // for a long stretch whenever the backpressure test asks for it.
  initial begin
    int n;
    out_if.ready = 1'b0;
    hold_off = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off_req && !hold_off) begin
        hold_off = 1;
        out_if.ready <= 1'b0;
        repeat (40) @(negedge clk_i);
        hold_off = 0;
      end
      n = $urandom_range(0, 3);
      if (n > 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      @(negedge clk_i);
    end
  end

  initial begin
    sentence_res_t e;
    fail_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        if (pending_q.size() == 0) begin
          $error("result with no expectation");
          fail_cnt++;
        end else begin
          e = pending_q.pop_front();
          if (out_if.body_count !== e.count) begin
            $error("body_count exp %0d got %0d", e.count, out_if.body_count); fail_cnt++;
          end
          if (out_if.body_char0 !== e.chars[0]) begin
            $error("body_char0 exp %h got %h", e.chars[0], out_if.body_char0); fail_cnt++;
          end
          if (out_if.body_char1 !== e.chars[1]) begin
            $error("body_char1 exp %h got %h", e.chars[1], out_if.body_char1); fail_cnt++;
          end
          if (out_if.body_char2 !== e.chars[2]) begin
            $error("body_char2 exp %h got %h", e.chars[2], out_if.body_char2); fail_cnt++;
          end
          if (out_if.body_char3 !== e.chars[3]) begin
            $error("body_char3 exp %h got %h", e.chars[3], out_if.body_char3); fail_cnt++;
          end
          if (out_if.body_char4 !== e.chars[4]) begin
            $error("body_char4 exp %h got %h", e.chars[4], out_if.body_char4); fail_cnt++;
          end
          if (out_if.sentence_ok !== e.ok) begin
            $error("sentence_ok exp %0d got %0d", e.ok, out_if.sentence_ok); fail_cnt++;
          end
          if (out_if.discard_code !== e.code) begin
            $error("discard_code exp %0d got %0d", e.code, out_if.discard_code); fail_cnt++;
          end
        end
      end
    end
  end

  initial begin
    int waited;
    rst_ni = 1'b0;
    hold_off_req = 0;
    in_if.valid = 1'b0; in_if.func = 1'b0; in_if.channel = '0; in_if.seq = '0;
    in_if.slow_byte0 = '0; in_if.slow_byte1 = '0; in_if.slow_byte2 = '0;
    for (int ch = 0; ch < dsax_pkg::Channels; ch++) clear_ctx(ch);
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_edges();
    test_good_sentences();
    test_bad_crc();
    test_long_sentences();
    test_backpressure();
    test_random();
    in_if.valid <= 1'b0;
    waited = 0;
    while (pending_q.size() > 0 && waited < 10000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (5) @(posedge clk_i);
    if (fail_cnt == 0 && pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/dsax_pkg.sv
rtl/core/dsax_if.sv
rtl/core/dsax_parse.sv
rtl/core/dstar_slow_data_aprs_extractor_unit.sv
tb/tb_top.sv
